[sv/tcf_pkg.sv]
package tcf_pkg;

  // fixed field widths
  localparam int SAMPLES_DEF = 5;
  localparam int BYTE_W      = 8;
  localparam int RAW_W       = 13;
  localparam int SUM_W       = 16;
  localparam int PIX_W       = 12;
  localparam int DIM_W       = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = RAW_W + PIX_W;
  localparam int MAX_DIM     = 4096;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_X   = 2'd0,
    KIND_Y   = 2'd1,
    KIND_PEN = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_RAW_MIN    = 3'd0,
    REG_X_RAW_MAX    = 3'd1,
    REG_Y_RAW_MIN    = 3'd2,
    REG_Y_RAW_MAX    = 3'd3,
    REG_PANEL_WIDTH  = 3'd4,
    REG_PANEL_HEIGHT = 3'd5
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MX_GO,
    S_MY_GO,
    S_PX_MUL,
    S_PX_GO,
    S_PX_WAIT,
    S_PY_MUL,
    S_PY_GO,
    S_PY_WAIT,
    S_EMIT,
    S_EMIT_UP
  } state_t;

  // what the shared divider works on
  typedef enum logic {
    SEL_MAP_X,
    SEL_MAP_Y
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     take_x;
    logic     take_y;
    logic     clear_axes;
    logic     mean_x;
    logic     mean_y;
    logic     mul_x;
    logic     mul_y;
    logic     div_start;
    logic     div_cap;
    div_sel_t div_sel;
    logic     load_out;
    logic     touch;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  pen;
    logic  complete;
    logic  div_done;
    logic  out_free;
  } sts_t;

endpackage

[sv/tcf_div.sv]
module tcf_div
  import tcf_pkg::*;
#(
  parameter int DVD_W = PROD_W,
  parameter int DVS_W = RAW_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = ~diff[DVS_W+1];
    rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[sv/tcf_ctrl.sv]
module tcf_ctrl
  import tcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && sts.kind == KIND_PEN) begin
          if (!sts.pen) begin
            state_nxt = S_EMIT_UP;
          end else if (sts.complete) begin
            state_nxt = S_MX_GO;
          end
        end
      end
      S_MX_GO:   state_nxt = S_MY_GO;
      S_MY_GO:   state_nxt = S_PX_MUL;
      S_PX_MUL:  state_nxt = S_PX_GO;
      S_PX_GO:   state_nxt = S_PX_WAIT;
      S_PX_WAIT: if (sts.div_done) state_nxt = S_PY_MUL;
      S_PY_MUL:  state_nxt = S_PY_GO;
      S_PY_GO:   state_nxt = S_PY_WAIT;
      S_PY_WAIT: if (sts.div_done) state_nxt = S_EMIT;
      S_EMIT:    if (sts.out_free) state_nxt = S_IDLE;
      S_EMIT_UP: if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.div_sel = SEL_MAP_X;
    in_tready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.take_x = in_tvalid && sts.kind == KIND_X;
        cmd.take_y = in_tvalid && sts.kind == KIND_Y;
      end
      S_MX_GO: begin
        cmd.mean_x = 1'b1;
      end
      S_MY_GO: begin
        cmd.mean_y = 1'b1;
      end
      S_PX_MUL: begin
        cmd.mul_x = 1'b1;
      end
      S_PX_GO: begin
        cmd.div_sel   = SEL_MAP_X;
        cmd.div_start = 1'b1;
      end
      S_PX_WAIT: begin
        cmd.div_sel = SEL_MAP_X;
        cmd.div_cap = sts.div_done;
      end
      S_PY_MUL: begin
        cmd.mul_y = 1'b1;
      end
      S_PY_GO: begin
        cmd.div_sel   = SEL_MAP_Y;
        cmd.div_start = 1'b1;
      end
      S_PY_WAIT: begin
        cmd.div_sel = SEL_MAP_Y;
        cmd.div_cap = sts.div_done;
      end
      S_EMIT: begin
        cmd.load_out   = sts.out_free;
        cmd.clear_axes = sts.out_free;
        cmd.touch      = 1'b1;
      end
      S_EMIT_UP: begin
        cmd.load_out   = sts.out_free;
        cmd.clear_axes = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[sv/tcf_datapath.sv]
module tcf_datapath
  import tcf_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int CNT_W = $clog2(SAMPLES + 1);

  // trimmed mean by reciprocal multiply: floor(t / d) = (t * ceil(2^sh / d)) >> sh
  localparam int MEAN_D   = SAMPLES - 2;
  localparam int REC_SH   = SUM_W + $clog2(MEAN_D);
  localparam int REC_W    = SUM_W + 1;
  localparam int MEAN_P_W = SUM_W + REC_W;
  localparam logic [REC_W-1:0] MEAN_REC = REC_W'(((1 << REC_SH) + MEAN_D - 1) / MEAN_D);

  // configuration
  logic [CFG_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r, width_r, height_r;

  // per axis accumulators, axis 0 is x and axis 1 is y
  logic [SUM_W-1:0] sum_r [2];
  logic [RAW_W-1:0] lo_r  [2];
  logic [RAW_W-1:0] hi_r  [2];
  logic [CNT_W-1:0] cnt_r [2];
  logic [SUM_W-1:0] sum_nxt [2];
  logic [RAW_W-1:0] lo_nxt  [2];
  logic [RAW_W-1:0] hi_nxt  [2];
  logic [CNT_W-1:0] cnt_nxt [2];

  logic [BYTE_W-1:0] high_byte, low_byte;
  logic [RAW_W-1:0]  raw;
  logic              take [2];

  logic [SUM_W-1:0]    mean_x_r, mean_y_r;
  logic [SUM_W-1:0]    trim_x, trim_y;
  logic [SUM_W-1:0]    mean_trim;
  logic [MEAN_P_W-1:0] mean_prod;
  logic [SUM_W-1:0]    mean_q;
  logic [PROD_W-1:0]   prod_r;
  logic [PIX_W-1:0]    xpix_r, ypix_r;
  logic [PIX_W-1:0]    last_x, last_y;
  logic [RAW_W-1:0]    mul_diff;
  logic [PIX_W-1:0]    mul_last;

  logic [PROD_W-1:0] div_dvd;
  logic [RAW_W-1:0]  div_dvs;
  logic [PROD_W-1:0] div_quo;
  logic              div_busy, div_done;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_x_r, out_y_r;
  logic              out_touch_r;

  // last pixel index of a panel dimension
  function automatic logic [PIX_W-1:0] last_pixel(input logic [DIM_W-1:0] dim);
    logic [PIX_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      res = '1;
    end else begin
      res = PIX_W'(dim - DIM_W'(1));
    end
    return res;
  endfunction

  // clamp and pick the scaled value
  function automatic logic [PIX_W-1:0] map_pixel(
    input logic [SUM_W-1:0]  mean,
    input logic [CFG_W-1:0]  rmin,
    input logic [CFG_W-1:0]  rmax,
    input logic [PIX_W-1:0]  last,
    input logic [PROD_W-1:0] quo
  );
    logic [PIX_W-1:0] res;
    if (mean <= SUM_W'(rmin)) begin
      res = '0;
    end else if (mean >= SUM_W'(rmax)) begin
      res = last;
    end else begin
      res = quo[PIX_W-1:0];
    end
    return res;
  endfunction

  // input fields
  assign high_byte = in_tdata[BYTE_W-1:0];
  assign low_byte  = in_tdata[2*BYTE_W-1:BYTE_W];
  assign raw       = {high_byte, low_byte[BYTE_W-1:3]};
  assign take[0]   = cmd.take_x;
  assign take[1]   = cmd.take_y;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= CFG_W'(200);
      x_max_r  <= CFG_W'(3900);
      y_min_r  <= CFG_W'(200);
      y_max_r  <= CFG_W'(3900);
      width_r  <= CFG_W'(240);
      height_r <= CFG_W'(320);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_RAW_MIN:    x_min_r  <= cfg_data;
        REG_X_RAW_MAX:    x_max_r  <= cfg_data;
        REG_Y_RAW_MIN:    y_min_r  <= cfg_data;
        REG_Y_RAW_MAX:    y_max_r  <= cfg_data;
        REG_PANEL_WIDTH:  width_r  <= cfg_data;
        REG_PANEL_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample accumulation and clearing
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum_nxt[a] = sum_r[a];
      lo_nxt[a]  = lo_r[a];
      hi_nxt[a]  = hi_r[a];
      cnt_nxt[a] = cnt_r[a];
      if (cmd.clear_axes) begin
        sum_nxt[a] = '0;
        lo_nxt[a]  = '1;
        hi_nxt[a]  = '0;
        cnt_nxt[a] = '0;
      end else if (take[a] && cnt_r[a] < CNT_W'(SAMPLES)) begin
        sum_nxt[a] = sum_r[a] + SUM_W'(raw);
        lo_nxt[a]  = (raw < lo_r[a]) ? raw : lo_r[a];
        hi_nxt[a]  = (raw > hi_r[a]) ? raw : hi_r[a];
        cnt_nxt[a] = cnt_r[a] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        sum_r[a] <= '0;
        lo_r[a]  <= '1;
        hi_r[a]  <= '0;
        cnt_r[a] <= '0;
      end
    end else begin
      for (int a = 0; a < 2; a++) begin
        sum_r[a] <= sum_nxt[a];
        lo_r[a]  <= lo_nxt[a];
        hi_r[a]  <= hi_nxt[a];
        cnt_r[a] <= cnt_nxt[a];
      end
    end
  end

  // trimmed sums and panel limits
  assign trim_x = sum_r[0] - SUM_W'(lo_r[0]) - SUM_W'(hi_r[0]);
  assign trim_y = sum_r[1] - SUM_W'(lo_r[1]) - SUM_W'(hi_r[1]);
  assign last_x = last_pixel(width_r);
  assign last_y = last_pixel(height_r);

  // shared mean multiplier, one axis per cycle
  assign mean_trim = cmd.mean_y ? trim_y : trim_x;
  assign mean_prod = MEAN_P_W'(mean_trim) * MEAN_P_W'(MEAN_REC);
  assign mean_q    = SUM_W'(mean_prod >> REC_SH);

  always_ff @(posedge clk) begin
    if (cmd.mean_x) begin
      mean_x_r <= mean_q;
    end
    if (cmd.mean_y) begin
      mean_y_r <= mean_q;
    end
  end

  // shared multiplier, offset from raw_min times last pixel
  assign mul_diff = cmd.mul_x ? (mean_x_r[RAW_W-1:0] - x_min_r)
                              : (mean_y_r[RAW_W-1:0] - y_min_r);
  assign mul_last = cmd.mul_x ? last_x : last_y;

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= PROD_W'(mul_diff) * PROD_W'(mul_last);
    end
  end

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      SEL_MAP_X: begin
        div_dvd = prod_r;
        div_dvs = x_max_r - x_min_r;
      end
      default: begin
        div_dvd = prod_r;
        div_dvs = y_max_r - y_min_r;
      end
    endcase
  end

  tcf_div #(
    .DVD_W (PROD_W),
    .DVS_W (RAW_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // quotient capture
  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        SEL_MAP_X: xpix_r <= map_pixel(mean_x_r, x_min_r, x_max_r, last_x, div_quo);
        default:   ypix_r <= map_pixel(mean_y_r, y_min_r, y_max_r, last_y, div_quo);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_r     <= cmd.touch ? xpix_r : '0;
      out_y_r     <= cmd.touch ? ypix_r : '0;
      out_touch_r <= cmd.touch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_touch_r;

  // status to controller
  assign sts.kind     = kind_t'(in_tuser);
  assign sts.pen      = in_tdata[2*BYTE_W];
  assign sts.complete = (cnt_r[0] == CNT_W'(SAMPLES)) && (cnt_r[1] == CNT_W'(SAMPLES));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(SAMPLES)) && (cnt_r[1] <= CNT_W'(SAMPLES)))
    else $error("axis sample count past limit");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r[0] == '0) || (lo_r[0] <= hi_r[0])) &&
    ((cnt_r[1] == '0) || (lo_r[1] <= hi_r[1])))
    else $error("axis minimum above maximum");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  a_cap_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_cap |-> (div_done && !div_busy))
    else $error("quotient taken before divide finished");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> div_busy)
    else $error("divide start lost");

endmodule

[sv/touch_coordinate_filter.sv]
// sample requests give no result; a new request is taken the next cycle
// a pen-up check goes through S_EMIT_UP, which loads its result once the output register is free
// a pen-down check with both axes full: one reciprocal multiply per trimmed mean, then
// per axis a multiply and a restoring divide (25 steps), then the result is loaded
// the output register holds a result while sample requests keep being taken
// rst_n is synchronous: registers back to reset values, axes cleared, no pending result
module touch_coordinate_filter
  import tcf_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: high_byte [7:0], low_byte [15:8], pen_down [16], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind [1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: x_pixel [11:0], y_pixel [23:12]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: touch_valid [0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  tcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcf_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tcf_pkg::*;

  localparam int N_SAMPLES    = SAMPLES_DEF;
  localparam int RAW_MAX      = (1 << RAW_W) - 1;
  localparam int LATENCY_WAIT = 160;
  localparam int ITEM_TARGET  = 1900;
  localparam int N_PHASES     = 9;

  // kind code that the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // register indexes past the last register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_PANEL_HEIGHT + 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(REG_PANEL_HEIGHT + 2);

  typedef struct packed {
    logic             touch;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] x;
  } coord_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_JITTER,
    RX_CHOKE
  } rx_mode_t;

  // running axis filter and calibration, plus the coordinates still owed
  class touch_coords;
    logic [CFG_W-1:0] cal [0:7];
    logic [SUM_W-1:0] acc_sum [0:1];
    logic [RAW_W-1:0] acc_min [0:1];
    logic [RAW_W-1:0] acc_max [0:1];
    logic [3:0]       acc_cnt [0:1];
    coord_t           coords_due [$];
    int               errors;
    int               used_items;

    function new();
      foreach (cal[i]) cal[i] = '0;
      cal[REG_X_RAW_MIN]    = CFG_W'(200);
      cal[REG_X_RAW_MAX]    = CFG_W'(3900);
      cal[REG_Y_RAW_MIN]    = CFG_W'(200);
      cal[REG_Y_RAW_MAX]    = CFG_W'(3900);
      cal[REG_PANEL_WIDTH]  = CFG_W'(240);
      cal[REG_PANEL_HEIGHT] = CFG_W'(320);
      errors     = 0;
      used_items = 0;
      clear_axes();
    endfunction

    function void clear_axes();
      for (int a = 0; a < 2; a++) begin
        acc_sum[a] = '0;
        acc_min[a] = '1;
        acc_max[a] = '0;
        acc_cnt[a] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      cal[idx] = val;
    endfunction

    function int pending();
      return coords_due.size();
    endfunction

    // average of the middle readings of one axis
    function logic [RAW_W-1:0] middle_mean(int a);
      logic [SUM_W-1:0] trimmed;
      int unsigned      q;
      trimmed = acc_sum[a] - SUM_W'(acc_min[a]) - SUM_W'(acc_max[a]);
      q = trimmed / (N_SAMPLES - 2);
      return q[RAW_W-1:0];
    endfunction

    // linear map onto the panel, clamped at both ends
    function logic [PIX_W-1:0] scale_axis(logic [RAW_W-1:0] v, logic [CFG_W-1:0] lo,
                                          logic [CFG_W-1:0] hi, logic [CFG_W-1:0] dim);
      int unsigned last_px;
      int unsigned px;
      last_px = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : dim);
      last_px = last_px - 1;
      if (v <= lo) px = 0;
      else if (v >= hi) px = last_px;
      else px = (int'(v - lo) * last_px) / int'(hi - lo);
      return px[PIX_W-1:0];
    endfunction

    function void take_request(logic [1:0] kind, logic [7:0] hb, logic [7:0] lb, logic pen);
      logic [RAW_W-1:0] raw;
      coord_t           c;
      int               a;
      raw = {hb, lb[7:3]};
      a   = (kind == KIND_Y) ? 1 : 0;
      case (kind)
        KIND_X, KIND_Y: begin
          if (acc_cnt[a] < N_SAMPLES) begin
            if (raw < acc_min[a]) acc_min[a] = raw;
            if (raw > acc_max[a]) acc_max[a] = raw;
            acc_sum[a] = acc_sum[a] + SUM_W'(raw);
            acc_cnt[a] = acc_cnt[a] + 4'd1;
            used_items++;
          end
        end
        KIND_PEN: begin
          used_items++;
          if (!pen) begin
            coords_due.push_back('0);
            clear_axes();
          end else if (acc_cnt[0] == N_SAMPLES && acc_cnt[1] == N_SAMPLES) begin
            c.x = scale_axis(middle_mean(0), cal[REG_X_RAW_MIN], cal[REG_X_RAW_MAX],
                             cal[REG_PANEL_WIDTH]);
            c.y = scale_axis(middle_mean(1), cal[REG_Y_RAW_MIN], cal[REG_Y_RAW_MAX],
                             cal[REG_PANEL_HEIGHT]);
            c.touch = 1'b1;
            coords_due.push_back(c);
            clear_axes();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_miss(string what, coord_t want, coord_t got);
      errors++;
      if (errors <= 10)
        $display("mismatch (%s): expected x=%0d y=%0d touch=%0b, got x=%0d y=%0d touch=%0b",
                 what, want.x, want.y, want.touch, got.x, got.y, got.touch);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      coord_t got;
      coord_t want;
      got.x     = d[PIX_W-1:0];
      got.y     = d[2*PIX_W-1:PIX_W];
      got.touch = u[0];
      if (coords_due.size() == 0) begin
        note_miss("result with nothing owed", '0, got);
        return;
      end
      want = coords_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.touch !== want.touch)
        note_miss("wrong coordinates", want, got);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  touch_coords coords = new();

  int          burst_left = 0;
  logic        steady = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold = 0;

  touch_coordinate_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: open stretches, random jitter, long chokes
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(40, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_JITTER: out_tready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_hold == 0) begin
          out_tready <= !out_tready;
          rx_hold    <= out_tready ? $urandom_range(1, 24) : $urandom_range(0, 4);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) coords.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        coords.take_request(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[16]);
      if (cfg_valid && cfg_ready) coords.set_reg(cfg_index, cfg_data);
    end
  end

  function automatic logic [RAW_W-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > RAW_MAX) return RAW_W'(RAW_MAX);
    return RAW_W'(v);
  endfunction

  // touch position biased toward the calibration edges and the range ends
  function automatic logic [RAW_W-1:0] pick_raw(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, RAW_MAX));
      1: v = int'(lo) + int'($urandom_range(0, 80)) - 40;
      2: v = int'(hi) + int'($urandom_range(0, 80)) - 40;
      3: v = 0;
      4: v = RAW_MAX;
      default: v = (lo < hi) ? int'($urandom_range(lo, hi)) : int'($urandom_range(0, RAW_MAX));
    endcase
    return clamp_raw(v);
  endfunction

  task automatic pause_input(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // one input request, with bursts and random gaps in front
  task automatic push_item(logic [1:0] kind, logic [7:0] hb, logic [7:0] lb, logic pen);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady && $urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, pen, lb, hb};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_sample(logic [1:0] kind, logic [RAW_W-1:0] center, int spread);
    logic [RAW_W-1:0] raw;
    raw = clamp_raw(int'(center) + int'($urandom_range(0, 2 * spread)) - spread);
    push_item(kind, raw[12:5], {raw[4:0], 3'($urandom_range(0, 7))},
              1'($urandom_range(0, 1)));
  endtask

  task automatic push_noise();
    push_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // samples of one touch, sometimes short or with extras, then a pen check
  task automatic touch_gesture();
    logic [RAW_W-1:0] cx;
    logic [RAW_W-1:0] cy;
    int               nx;
    int               ny;
    int               spread;
    int               roll;
    cx     = pick_raw(coords.cal[REG_X_RAW_MIN], coords.cal[REG_X_RAW_MAX]);
    cy     = pick_raw(coords.cal[REG_Y_RAW_MIN], coords.cal[REG_Y_RAW_MAX]);
    spread = ($urandom_range(0, 3) == 0) ? 700 : 24;
    roll   = $urandom_range(0, 19);
    nx     = N_SAMPLES;
    ny     = N_SAMPLES;
    steady = ($urandom_range(0, 4) == 0);
    if (roll < 3) nx = $urandom_range(0, N_SAMPLES - 1);
    else if (roll < 5) ny = $urandom_range(0, N_SAMPLES - 1);
    else if (roll < 8) begin
      nx += $urandom_range(0, 3);
      ny += $urandom_range(0, 3);
    end
    while (nx > 0 || ny > 0) begin
      if (nx > 0 && (ny == 0 || $urandom_range(0, 1) == 1)) begin
        push_sample(KIND_X, cx, spread);
        nx--;
      end else begin
        push_sample(KIND_Y, cy, spread);
        ny--;
      end
      if ($urandom_range(0, 40) == 0) push_noise();
    end
    push_item(KIND_PEN, 8'($urandom), 8'($urandom), (roll != 19));
    // short touches usually end with the pen lifting
    if (roll < 5 && $urandom_range(0, 2) != 0)
      push_item(KIND_PEN, 8'($urandom), 8'($urandom), 1'b0);
    if ($urandom_range(0, 7) == 0) push_noise();
  endtask

  // block idle: nothing owed and the longest computation over
  task automatic drain();
    in_tvalid <= 1'b0;
    while (coords.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cal(int x0, int x1, int y0, int y1, int w, int h);
    cfg_write(REG_X_RAW_MIN, CFG_W'(x0));
    cfg_write(REG_X_RAW_MAX, CFG_W'(x1));
    cfg_write(REG_Y_RAW_MIN, CFG_W'(y0));
    cfg_write(REG_Y_RAW_MAX, CFG_W'(y1));
    cfg_write(REG_PANEL_WIDTH, CFG_W'(w));
    cfg_write(REG_PANEL_HEIGHT, CFG_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int which);
    int lo;
    int hi;
    int lo2;
    int hi2;
    case (which)
      // full raw range on the largest panel
      0: load_cal(0, RAW_MAX, 0, RAW_MAX, MAX_DIM, MAX_DIM);
      // inverted and flat ranges, zero-size and one-pixel panels
      1: load_cal(5000, 3000, 4000, 4000, 0, 1);
      // min at the top, max at the bottom, oversized panels
      2: load_cal(RAW_MAX, 0, 0, 1, RAW_MAX, MAX_DIM + 1);
      3: load_cal(100, 300, 50, 8000, 2, MAX_DIM - 1);
      default: begin
        lo  = $urandom_range(0, RAW_MAX);
        hi  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RAW_MAX)
                                           : $urandom_range(lo, RAW_MAX);
        lo2 = $urandom_range(0, RAW_MAX);
        hi2 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RAW_MAX)
                                           : $urandom_range(lo2, RAW_MAX);
        if ($urandom_range(0, 2) == 0) begin
          cfg_write(REG_SPARE_LO, CFG_W'($urandom));
          cfg_write(REG_SPARE_HI, CFG_W'($urandom));
        end
        load_cal(lo, hi, lo2, hi2,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, RAW_MAX)
                                             : $urandom_range(1, MAX_DIM),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, RAW_MAX)
                                             : $urandom_range(1, MAX_DIM));
      end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty checks, byte extremes, extra sample, ignored kind
    push_item(KIND_PEN, 8'h00, 8'h00, 1'b0);
    push_item(KIND_PEN, 8'hFF, 8'hFF, 1'b1);
    push_item(KIND_X, 8'hFF, 8'hFF, 1'b0);
    push_item(KIND_X, 8'h00, 8'h00, 1'b1);
    push_item(KIND_X, 8'h00, 8'h07, 1'b0);
    push_item(KIND_X, 8'h80, 8'h08, 1'b1);
    push_item(KIND_X, 8'h55, 8'hAA, 1'b0);
    push_item(KIND_X, 8'hAA, 8'h55, 1'b1);
    push_item(KIND_Y, 8'h06, 8'h40, 1'b0);
    push_item(KIND_Y, 8'h79, 8'hE0, 1'b1);
    push_item(KIND_Y, 8'h7A, 8'h00, 1'b0);
    push_item(KIND_Y, 8'h10, 8'h00, 1'b0);
    push_item(KIND_SPARE, 8'hFF, 8'hFF, 1'b1);
    push_item(KIND_PEN, 8'h00, 8'h00, 1'b1);
    push_item(KIND_Y, 8'h10, 8'hF8, 1'b1);
    push_item(KIND_PEN, 8'h00, 8'h00, 1'b1);
    push_item(KIND_X, 8'h20, 8'h00, 1'b0);
    push_item(KIND_Y, 8'h20, 8'h00, 1'b0);
    push_item(KIND_PEN, 8'hFF, 8'h00, 1'b0);
    push_item(KIND_PEN, 8'h00, 8'hFF, 1'b1);

    // random touches under a sequence of calibrations
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        apply_setting(ph - 1);
      end
      while (coords.used_items < (ph + 1) * ITEM_TARGET / N_PHASES) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        else touch_gesture();
      end
    end

    drain();
    if (coords.errors == 0 && coords.pending() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[touch_coordinate_filter.f]
sv/tcf_pkg.sv
sv/tcf_div.sv
sv/tcf_ctrl.sv
sv/tcf_datapath.sv
sv/touch_coordinate_filter.sv
verif/tb.sv
